// File: hdl/hrlf_pkg.sv
// Shared constants, types and the keyword table of the HTTP response length framer.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package hrlf_pkg;

   // default widths of the length value and of the byte counters
   localparam int DEF_VALUE_BITS = 31;
   localparam int DEF_COUNT_BITS = 24;

   // field widths of the channels
   localparam int BYTE_W   = 8;
   localparam int CFG_W    = 24;
   localparam int HDR_W    = 24;
   localparam int BODY_W   = 31;
   localparam int TOTAL_W  = 24;

   // reset value of the byte limit register
   localparam logic [CFG_W-1:0] MAX_RESPONSE_RESET = 24'd16384;

   // CR LF "content-length:" in lower case
   localparam int KEY_LEN = 17;
   localparam int KEY_W   = $clog2(KEY_LEN + 1);

   // byte codes
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

   // result status codes
   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   // one result beat
   typedef struct packed {
      logic               status;
      logic [HDR_W-1:0]   header_length;
      logic [BODY_W-1:0]  body_length;
      logic [TOTAL_W-1:0] total_length;
      logic               length_seen;
      logic               length_saturated;
   } result_type;

   // keyword character at a match position
   function automatic logic [BYTE_W-1:0] key_char(input logic [KEY_W-1:0] pos);
      logic [BYTE_W-1:0] c;
      case (pos)
         5'd0:    c = CHAR_CR;
         5'd1:    c = CHAR_LF;
         5'd2:    c = 8'h63; // c
         5'd3:    c = 8'h6F; // o
         5'd4:    c = 8'h6E; // n
         5'd5:    c = 8'h74; // t
         5'd6:    c = 8'h65; // e
         5'd7:    c = 8'h6E; // n
         5'd8:    c = 8'h74; // t
         5'd9:    c = 8'h2D; // -
         5'd10:   c = 8'h6C; // l
         5'd11:   c = 8'h65; // e
         5'd12:   c = 8'h6E; // n
         5'd13:   c = 8'h67; // g
         5'd14:   c = 8'h74; // t
         5'd15:   c = 8'h68; // h
         5'd16:   c = 8'h3A; // :
         default: c = CHAR_CR;
      endcase
      return c;
   endfunction

endpackage

// File: hdl/hrlf_channels.sv
// Handshake channel interfaces of the framer: received bytes, results and the limit register.
// Depends on hrlf_pkg for field widths and the result layout.
`timescale 1ns / 1ps

// received byte stream
interface hrlf_req_if;
   logic                        valid;
   logic                        ready;
   logic [hrlf_pkg::BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// framing results
interface hrlf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         status;
   logic [hrlf_pkg::HDR_W-1:0]   header_length;
   logic [hrlf_pkg::BODY_W-1:0]  body_length;
   logic [hrlf_pkg::TOTAL_W-1:0] total_length;
   logic                         length_seen;
   logic                         length_saturated;
   modport source (output valid, output status, output header_length, output body_length,
                   output total_length, output length_seen, output length_saturated,
                   input ready);
   modport sink   (input valid, input status, input header_length, input body_length,
                   input total_length, input length_seen, input length_saturated,
                   output ready);
endinterface

// byte limit register writes
interface hrlf_csr_if;
   logic                       valid;
   logic                       ready;
   logic [hrlf_pkg::CFG_W-1:0] max_response_bytes;
   modport source (output valid, output max_response_bytes, input ready);
   modport sink   (input valid, input max_response_bytes, output ready);
endinterface

// File: hdl/http_response_length_framer_unit.sv
// Top level of the HTTP response length framer: header scan, length decode and body count.
// Depends on hrlf_pkg and the channel interfaces in hrlf_channels.sv.
//
//  port     | dir | beat carries
//  ---------+-----+-----------------------------------------------------------
//  req_if   | in  | rx_byte: one received byte of the response stream
//  rsp_if   | out | status, header/body/total length, length_seen, saturated
//  csr_if   | in  | max_response_bytes: byte limit of one response
//
// One byte is taken every clock while the input is not stalled. A byte waits in the
// input register until it fires and then updates the scan state; its result (if any)
// is written into the result queue and shows at rsp_if once the results ahead of it are
// taken. Results queue in a two-entry buffer; input stalls only while both entries wait and rsp_if
// is not ready. Synchronous reset clears the scan state and the queue and loads
// the byte limit with its default.
`timescale 1ns / 1ps

module http_response_length_framer_unit #(
   parameter int VALUE_BITS = hrlf_pkg::DEF_VALUE_BITS,
   parameter int COUNT_BITS = hrlf_pkg::DEF_COUNT_BITS
) (
   input logic        clock,
   input logic        reset,
   hrlf_req_if.sink   req_if,
   hrlf_rsp_if.source rsp_if,
   hrlf_csr_if.sink   csr_if
);

   localparam int LIM_W  = 33;
   localparam int SUM_W  = ((VALUE_BITS > COUNT_BITS) ? VALUE_BITS : COUNT_BITS) + 1;
   localparam int MUL_W  = VALUE_BITS + 4;
   localparam int WIDE_W = 64;
   localparam logic [LIM_W-1:0] COUNT_MAX = (LIM_W'(1) << COUNT_BITS) - LIM_W'(1);

   typedef enum logic [1:0] {
      PHASE_KEY,
      PHASE_BLANK,
      PHASE_DIGITS,
      PHASE_DONE
   } phase_type;

   // input register
   logic                        in_valid_ff;
   logic [hrlf_pkg::BYTE_W-1:0] in_byte_ff;

   // byte limit
   logic [hrlf_pkg::CFG_W-1:0] max_bytes_ff;

   // scan state
   logic                       in_body_ff,   in_body_in;
   logic [1:0]                 term_ff,      term_in;
   logic [hrlf_pkg::KEY_W-1:0] key_ff,       key_in;
   phase_type                  phase_ff,     phase_in;
   logic [VALUE_BITS-1:0]      value_ff,     value_in;
   logic [COUNT_BITS-1:0]      hdr_cnt_ff,   hdr_cnt_in;
   logic [COUNT_BITS-1:0]      byte_cnt_ff,  byte_cnt_in;
   logic                       seen_ff,      seen_in;
   logic                       sat_ff,       sat_in;

   // result queue
   hrlf_pkg::result_type slot0_ff, slot1_ff;
   logic [1:0]           count_ff;

   // step signals
   logic                        fire;
   logic                        pop;
   logic                        res_valid;
   hrlf_pkg::result_type        res;
   logic [hrlf_pkg::BYTE_W-1:0] b;
   logic [hrlf_pkg::BYTE_W-1:0] folded;
   logic [hrlf_pkg::KEY_W-1:0]  key_pos;
   logic                        is_digit;
   logic [3:0]                  digit;
   logic [MUL_W-1:0]            value_ext;
   logic [MUL_W-1:0]            value_mul;
   logic [LIM_W-1:0]            limit;
   logic [SUM_W-1:0]            total_sum;
   logic [WIDE_W-1:0]           hdr_wide;
   logic [WIDE_W-1:0]           value_wide;
   logic [WIDE_W-1:0]           total_wide;
   logic [WIDE_W-1:0]           cnt_wide;

   // handshakes
   assign pop          = (count_ff != 2'd0) && rsp_if.ready;
   assign fire         = in_valid_ff && ((count_ff != 2'd2) || pop);
   assign req_if.ready = !in_valid_ff || fire;
   assign csr_if.ready = 1'b1;

   // effective limit, capped at the counter range
   always_comb begin
      limit = LIM_W'(max_bytes_ff);
      if (limit > COUNT_MAX) limit = COUNT_MAX;
   end

   // byte decode
   assign b        = in_byte_ff;
   assign folded   = ((b >= hrlf_pkg::CHAR_UPPER_A) && (b <= hrlf_pkg::CHAR_UPPER_Z)) ?
                     (b + hrlf_pkg::CASE_OFFSET) : b;
   assign key_pos  = (key_ff < hrlf_pkg::KEY_W'(hrlf_pkg::KEY_LEN)) ? key_ff : '0;
   assign is_digit = (b >= hrlf_pkg::CHAR_ZERO) && (b <= hrlf_pkg::CHAR_NINE);
   assign digit    = 4'(b - hrlf_pkg::CHAR_ZERO);

   // value * 10 + digit; any of the top four bits set means saturation
   assign value_ext = MUL_W'(value_ff);
   assign value_mul = (value_ext << 3) + (value_ext << 1) + MUL_W'(digit);

   // one byte of scan
   always_comb begin
      in_body_in  = in_body_ff;
      term_in     = term_ff;
      key_in      = key_ff;
      phase_in    = phase_ff;
      value_in    = value_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      byte_cnt_in = byte_cnt_ff;
      seen_in     = seen_ff;
      sat_in      = sat_ff;
      res_valid   = 1'b0;
      res         = '0;
      total_sum   = '0;
      hdr_wide    = '0;
      value_wide  = '0;
      total_wide  = '0;
      cnt_wide    = '0;

      if (fire) begin
         if (LIM_W'(byte_cnt_ff) >= limit) begin
            // limit reached: report and drop this byte
            hdr_wide  = WIDE_W'(hdr_cnt_ff);
            value_wide = WIDE_W'(value_ff);
            cnt_wide  = WIDE_W'(byte_cnt_ff);
            res_valid = 1'b1;
            res.status           = hrlf_pkg::STATUS_OVERFLOW;
            res.header_length    = hdr_wide[hrlf_pkg::HDR_W-1:0];
            res.body_length      = value_wide[hrlf_pkg::BODY_W-1:0];
            res.total_length     = cnt_wide[hrlf_pkg::TOTAL_W-1:0];
            res.length_seen      = seen_ff;
            res.length_saturated = sat_ff;
         end else begin
            byte_cnt_in = byte_cnt_ff + COUNT_BITS'(1);

            if (!in_body_ff) begin
               // keyword match and value decode
               case (phase_ff)
                  PHASE_KEY: begin
                     if (folded == hrlf_pkg::key_char(key_pos)) begin
                        if (key_pos == hrlf_pkg::KEY_W'(hrlf_pkg::KEY_LEN - 1)) begin
                           key_in   = '0;
                           phase_in = PHASE_BLANK;
                           seen_in  = 1'b1;
                        end else begin
                           key_in = key_pos + hrlf_pkg::KEY_W'(1);
                        end
                     end else begin
                        key_in = (b == hrlf_pkg::CHAR_CR) ? hrlf_pkg::KEY_W'(1) : '0;
                     end
                  end
                  PHASE_BLANK, PHASE_DIGITS: begin
                     if ((phase_ff == PHASE_BLANK) &&
                         ((b == hrlf_pkg::CHAR_SPACE) || (b == hrlf_pkg::CHAR_TAB))) begin
                        phase_in = PHASE_BLANK;
                     end else if (is_digit) begin
                        phase_in = PHASE_DIGITS;
                        if (value_mul[MUL_W-1 -: 4] != 4'd0) begin
                           value_in = '1;
                           sat_in   = 1'b1;
                        end else begin
                           value_in = value_mul[VALUE_BITS-1:0];
                        end
                     end else begin
                        phase_in = PHASE_DONE;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase

               // CR LF CR LF search
               if (b == (term_ff[0] ? hrlf_pkg::CHAR_LF : hrlf_pkg::CHAR_CR)) begin
                  if (term_ff == 2'd3) begin
                     term_in    = 2'd0;
                     in_body_in = 1'b1;
                     hdr_cnt_in = byte_cnt_in;
                  end else begin
                     term_in = term_ff + 2'd1;
                  end
               end else begin
                  term_in = (b == hrlf_pkg::CHAR_CR) ? 2'd1 : 2'd0;
               end
            end

            // body complete check
            if (in_body_in) begin
               total_sum = SUM_W'(hdr_cnt_in) + SUM_W'(value_in);
               if (SUM_W'(byte_cnt_in) >= total_sum) begin
                  hdr_wide   = WIDE_W'(hdr_cnt_in);
                  value_wide = WIDE_W'(value_in);
                  total_wide = WIDE_W'(total_sum);
                  res_valid  = 1'b1;
                  res.status           = hrlf_pkg::STATUS_DONE;
                  res.header_length    = hdr_wide[hrlf_pkg::HDR_W-1:0];
                  res.body_length      = value_wide[hrlf_pkg::BODY_W-1:0];
                  res.total_length     = total_wide[hrlf_pkg::TOTAL_W-1:0];
                  res.length_seen      = seen_in;
                  res.length_saturated = sat_in;
               end
            end
         end

         // any result starts a new response
         if (res_valid) begin
            in_body_in  = 1'b0;
            term_in     = 2'd0;
            key_in      = '0;
            phase_in    = PHASE_KEY;
            value_in    = '0;
            hdr_cnt_in  = '0;
            byte_cnt_in = '0;
            seen_in     = 1'b0;
            sat_in      = 1'b0;
         end
      end
   end

   // input register and byte limit
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         max_bytes_ff <= hrlf_pkg::MAX_RESPONSE_RESET;
      end else begin
         if (req_if.valid && req_if.ready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (csr_if.valid) begin
            max_bytes_ff <= csr_if.max_response_bytes;
         end
      end
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.rx_byte;
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff  <= 1'b0;
         term_ff     <= 2'd0;
         key_ff      <= '0;
         phase_ff    <= PHASE_KEY;
         value_ff    <= '0;
         hdr_cnt_ff  <= '0;
         byte_cnt_ff <= '0;
         seen_ff     <= 1'b0;
         sat_ff      <= 1'b0;
      end else begin
         in_body_ff  <= in_body_in;
         term_ff     <= term_in;
         key_ff      <= key_in;
         phase_ff    <= phase_in;
         value_ff    <= value_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         byte_cnt_ff <= byte_cnt_in;
         seen_ff     <= seen_in;
         sat_ff      <= sat_in;
      end
   end

   // two-entry result queue, slot0 is the head
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_ff + {1'b0, res_valid} - {1'b0, pop};
      end
      if (pop) begin
         if (count_ff == 2'd2) begin
            slot0_ff <= slot1_ff;
            if (res_valid) slot1_ff <= res;
         end else if (res_valid) begin
            slot0_ff <= res;
         end
      end else if (res_valid) begin
         if (count_ff == 2'd0) slot0_ff <= res;
         else slot1_ff <= res;
      end
   end

   // result port
   assign rsp_if.valid            = (count_ff != 2'd0);
   assign rsp_if.status           = slot0_ff.status;
   assign rsp_if.header_length    = slot0_ff.header_length;
   assign rsp_if.body_length      = slot0_ff.body_length;
   assign rsp_if.total_length     = slot0_ff.total_length;
   assign rsp_if.length_seen      = slot0_ff.length_seen;
   assign rsp_if.length_saturated = slot0_ff.length_saturated;

endmodule
